### rtl/gld_pkg.sv
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int STACK_DEPTH   = 4096;
    localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
    localparam int TABLE_AW      = MAX_CODE_BITS;
    localparam int STACK_AW      = $clog2(STACK_DEPTH);
    localparam int BUF_BITS      = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_INDEX  = 2'd2;

    // operation codes on the input beat
    localparam logic [1:0] OPC_PUSH    = 2'd0;
    localparam logic [1:0] OPC_READ    = 2'd1;
    localparam logic [1:0] OPC_RESTART = 2'd2;

    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_READ,
        KIND_RESTART,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] code_byte;
    } gld_in_t;

    typedef struct packed {
        logic       accepted;
        logic       pixel_valid;
        logic [7:0] pixel_index;
        logic       transparent;
        logic       end_of_image;
        logic       code_error;
    } gld_out_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] code_byte;
    } queue_item_t;

    typedef struct packed {
        logic [3:0] min_code_size;
        logic       transparent_enable;
        logic [7:0] transparent_index;
    } cfg_t;

endpackage

### rtl/gif_lzw_decoder.sv
// A push, restart or no-op beat passes through the input queue and is answered from the
// registered result. A read that finds a whole code runs DECODE first, and for a table code
// the chain walk (WALK_RD and WALK_DATA per table entry walked) and UPDATE, paced by the
// registered prefix/suffix table read; every read then passes POP and, when it pops a pixel,
// POP_WAIT. One push, restart or no-op beat per cycle while the result is not stalled; a read
// holds the decoder until it is answered. Reset (rst_n, asynchronous, active low) empties
// the queue and result register and loads the decoder state; memories are not cleared.
module gif_lzw_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  gld_pkg::gld_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output gld_pkg::gld_out_t                    out_data,
    input  logic                                 cfg_write,
    input  logic [gld_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gld_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gld_pkg::*;

    cfg_t        cfg_reg;
    logic        q_valid;
    logic        q_pop;
    queue_item_t q_data;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_code_size      <= 4'd8;
            cfg_reg.transparent_enable <= 1'b0;
            cfg_reg.transparent_index  <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_CODE_SIZE:      cfg_reg.min_code_size      <= cfg_data[3:0];
                REG_TRANSPARENT_ENABLE: cfg_reg.transparent_enable <= cfg_data[0];
                REG_TRANSPARENT_INDEX:  cfg_reg.transparent_index  <= cfg_data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    gld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    gld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### rtl/gld_front.sv
module gld_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gld_pkg::gld_in_t     in_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output gld_pkg::queue_item_t q_data
);
    import gld_pkg::*;

    queue_item_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    queue_item_t item;
    logic        push;
    logic        pop;

    // classify the incoming beat
    always_comb
    begin
        item.code_byte = in_data.code_byte;
        case (in_data.operation)
            OPC_PUSH:    item.kind = KIND_PUSH;
            OPC_READ:    item.kind = KIND_READ;
            OPC_RESTART: item.kind = KIND_RESTART;
            default:     item.kind = KIND_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    // store accepted beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/gld_back.sv
module gld_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gld_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  gld_pkg::queue_item_t q_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gld_pkg::gld_out_t    out_data
);
    import gld_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK_RD,
        ST_WALK_DATA,
        ST_UPDATE,
        ST_POP,
        ST_POP_WAIT
    } state_t;

    typedef enum logic [2:0] {
        DEC_CLEAR,
        DEC_END,
        DEC_ERROR,
        DEC_LITERAL,
        DEC_KNOWN,
        DEC_KWKWK
    } dec_t;

    state_t           state_reg;
    logic [19:0]      buf_reg;
    logic [4:0]       bit_count_reg;
    logic [3:0]       code_width_reg;
    logic [12:0]      next_free_reg;
    logic [11:0]      prev_code_reg;
    logic             prev_valid_reg;
    logic [7:0]       first_prev_reg;
    logic [12:0]      sp_reg;
    logic             done_reg;
    logic [11:0]      code_reg;
    logic [11:0]      cur_reg;
    logic [12:0]      steps_reg;
    logic [7:0]       first_reg;
    logic             err_reg;
    logic             res_valid_reg;
    gld_out_t         res_reg;

    logic [11:0]      prefix_mem [TABLE_SIZE];
    logic [7:0]       suffix_mem [TABLE_SIZE];
    logic [7:0]       stack_mem  [STACK_DEPTH];
    logic [11:0]      prefix_q;
    logic [7:0]       suffix_q;
    logic [7:0]       stack_q;

    logic [3:0]       eff_size;
    logic [12:0]      clear_code;
    logic [12:0]      clear_p2;
    logic [11:0]      code_mask;
    logic [11:0]      new_code;
    logic             slot_free;
    logic             start;
    logic             push_fits;
    logic             can_decode;
    logic             walk_more;
    dec_t             dec;
    logic             stk_we;
    logic [7:0]       stk_wdata;
    logic             stk_push;
    logic             tbl_we;
    logic [12:0]      next_free_inc;
    logic [12:0]      width_limit;

    // live code sizes from the register
    always_comb
    begin
        if (cfg.min_code_size < 4'd2)
        begin
            eff_size = 4'd2;
        end
        else if (cfg.min_code_size > 4'd8)
        begin
            eff_size = 4'd8;
        end
        else
        begin
            eff_size = cfg.min_code_size;
        end
    end

    assign clear_code    = 13'd1 << eff_size;
    assign clear_p2      = clear_code + 13'd2;
    assign code_mask     = 12'((13'd1 << code_width_reg) - 13'd1);
    assign new_code      = buf_reg[11:0] & code_mask;
    assign slot_free     = !res_valid_reg || !out_stall;
    assign start         = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign q_pop         = start;
    assign push_fits     = ({1'b0, bit_count_reg} + 6'd8) <= 6'(BUF_BITS);
    assign can_decode    = (sp_reg == 13'd0) && !done_reg
                           && ({1'b0, bit_count_reg} >= {2'b00, code_width_reg});
    assign walk_more     = ({1'b0, cur_reg} >= clear_p2) && (steps_reg < 13'(TABLE_SIZE));
    assign next_free_inc = next_free_reg + 13'd1;
    assign width_limit   = 13'd1 << code_width_reg;
    assign tbl_we        = (state_reg == ST_UPDATE) && (next_free_reg < 13'(TABLE_SIZE));
    assign stk_push      = stk_we && (sp_reg < 13'(STACK_DEPTH));

    // classify the code under decode
    always_comb
    begin
        if ({1'b0, code_reg} == clear_code)
        begin
            dec = DEC_CLEAR;
        end
        else if ({1'b0, code_reg} == clear_code + 13'd1)
        begin
            dec = DEC_END;
        end
        else if (!prev_valid_reg)
        begin
            dec = ({1'b0, code_reg} > clear_code) ? DEC_ERROR : DEC_LITERAL;
        end
        else if ({1'b0, code_reg} < next_free_reg)
        begin
            dec = DEC_KNOWN;
        end
        else if (({1'b0, code_reg} == next_free_reg) && (next_free_reg < 13'(TABLE_SIZE)))
        begin
            dec = DEC_KWKWK;
        end
        else
        begin
            dec = DEC_ERROR;
        end
    end

    // select the character pushed on the stack this cycle
    always_comb
    begin
        stk_we    = 1'b0;
        stk_wdata = 8'd0;
        case (state_reg)
            ST_DECODE:
            begin
                if (dec == DEC_LITERAL)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = code_reg[7:0];
                end
                else if (dec == DEC_KWKWK)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = first_prev_reg;
                end
            end
            ST_WALK_RD:
            begin
                if (!walk_more)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = cur_reg[7:0];
                end
            end
            ST_WALK_DATA:
            begin
                stk_we    = 1'b1;
                stk_wdata = suffix_q;
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    // string table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            prefix_mem[next_free_reg[TABLE_AW-1:0]] <= prev_code_reg;
            suffix_mem[next_free_reg[TABLE_AW-1:0]] <= first_reg;
        end
        if ((state_reg == ST_WALK_RD) && walk_more)
        begin
            prefix_q <= prefix_mem[cur_reg];
            suffix_q <= suffix_mem[cur_reg];
        end
    end

    // pixel stack
    always_ff @(posedge clk)
    begin
        if (stk_push)
        begin
            stack_mem[sp_reg[STACK_AW-1:0]] <= stk_wdata;
        end
        if ((state_reg == ST_POP) && (sp_reg != 13'd0))
        begin
            stack_q <= stack_mem[STACK_AW'(sp_reg - 13'd1)];
        end
    end

    // sequencer, decoder state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            buf_reg        <= 20'd0;
            bit_count_reg  <= 5'd0;
            code_width_reg <= 4'd9;
            next_free_reg  <= 13'd258;
            prev_code_reg  <= 12'd0;
            prev_valid_reg <= 1'b0;
            first_prev_reg <= 8'd0;
            sp_reg         <= 13'd0;
            done_reg       <= 1'b0;
            code_reg       <= 12'd0;
            cur_reg        <= 12'd0;
            steps_reg      <= 13'd0;
            first_reg      <= 8'd0;
            err_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (res_valid_reg && !out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (stk_push)
            begin
                sp_reg <= sp_reg + 13'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        err_reg <= 1'b0;
                        res_reg <= '0;
                        case (q_data.kind)
                            KIND_PUSH:
                            begin
                                if (!done_reg && push_fits)
                                begin
                                    buf_reg <= 20'(buf_reg
                                               | (28'(q_data.code_byte) << bit_count_reg));
                                    bit_count_reg <= bit_count_reg + 5'd8;
                                end
                                res_valid_reg        <= 1'b1;
                                res_reg.accepted     <= done_reg || push_fits;
                                res_reg.end_of_image <= done_reg && (sp_reg == 13'd0);
                            end
                            KIND_READ:
                            begin
                                if (can_decode)
                                begin
                                    code_reg      <= new_code;
                                    buf_reg       <= buf_reg >> code_width_reg;
                                    bit_count_reg <= bit_count_reg - {1'b0, code_width_reg};
                                    state_reg     <= ST_DECODE;
                                end
                                else
                                begin
                                    state_reg <= ST_POP;
                                end
                            end
                            KIND_RESTART:
                            begin
                                buf_reg        <= 20'd0;
                                bit_count_reg  <= 5'd0;
                                sp_reg         <= 13'd0;
                                done_reg       <= 1'b0;
                                prev_code_reg  <= 12'd0;
                                first_prev_reg <= 8'd0;
                                prev_valid_reg <= 1'b0;
                                code_width_reg <= eff_size + 4'd1;
                                next_free_reg  <= clear_p2;
                                res_valid_reg  <= 1'b1;
                            end
                            default:
                            begin
                                res_valid_reg        <= 1'b1;
                                res_reg.end_of_image <= done_reg && (sp_reg == 13'd0);
                            end
                        endcase
                    end
                end
                ST_DECODE:
                begin
                    steps_reg <= 13'd0;
                    case (dec)
                        DEC_CLEAR:
                        begin
                            code_width_reg <= eff_size + 4'd1;
                            next_free_reg  <= clear_p2;
                            prev_valid_reg <= 1'b0;
                            state_reg      <= ST_POP;
                        end
                        DEC_END:
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_POP;
                        end
                        DEC_LITERAL:
                        begin
                            prev_code_reg  <= code_reg;
                            first_prev_reg <= code_reg[7:0];
                            prev_valid_reg <= 1'b1;
                            state_reg      <= ST_POP;
                        end
                        DEC_KNOWN:
                        begin
                            cur_reg   <= code_reg;
                            state_reg <= ST_WALK_RD;
                        end
                        DEC_KWKWK:
                        begin
                            cur_reg   <= prev_code_reg;
                            state_reg <= ST_WALK_RD;
                        end
                        default:
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_POP;
                        end
                    endcase
                end
                ST_WALK_RD:
                begin
                    if (walk_more)
                    begin
                        state_reg <= ST_WALK_DATA;
                    end
                    else
                    begin
                        first_reg <= cur_reg[7:0];
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_WALK_DATA:
                begin
                    cur_reg   <= prefix_q;
                    steps_reg <= steps_reg + 13'd1;
                    state_reg <= ST_WALK_RD;
                end
                ST_UPDATE:
                begin
                    if (next_free_reg < 13'(TABLE_SIZE))
                    begin
                        next_free_reg <= next_free_inc;
                        if ((next_free_inc == width_limit)
                            && (code_width_reg < 4'(MAX_CODE_BITS)))
                        begin
                            code_width_reg <= code_width_reg + 4'd1;
                        end
                    end
                    prev_code_reg  <= code_reg;
                    first_prev_reg <= first_reg;
                    state_reg      <= ST_POP;
                end
                ST_POP:
                begin
                    if (sp_reg != 13'd0)
                    begin
                        sp_reg    <= sp_reg - 13'd1;
                        state_reg <= ST_POP_WAIT;
                    end
                    else
                    begin
                        res_valid_reg        <= 1'b1;
                        res_reg.code_error   <= err_reg;
                        res_reg.end_of_image <= done_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                ST_POP_WAIT:
                begin
                    res_valid_reg        <= 1'b1;
                    res_reg.pixel_valid  <= 1'b1;
                    res_reg.pixel_index  <= stack_q;
                    res_reg.transparent  <= cfg.transparent_enable
                                            && (stack_q == cfg.transparent_index);
                    res_reg.code_error   <= err_reg;
                    res_reg.end_of_image <= done_reg && (sp_reg == 13'd0);
                    state_reg            <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

### rtl/gld_checker.sv
module gld_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input gld_pkg::gld_out_t out_data
);
    import gld_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed under stall");

    // no pixel means zero index and no transparency
    a_nopix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pixel_valid |->
            out_data.pixel_index == 8'd0 && !out_data.transparent)
        else $error("pixel fields set without a pixel");

    // an accepted push result carries no pixel and no error
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.accepted |-> !out_data.pixel_valid && !out_data.code_error)
        else $error("accepted push with pixel or error");

    // a code error result carries no accepted push and no end of image
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.code_error |-> !out_data.accepted && !out_data.end_of_image)
        else $error("code error with push or end flag");

endmodule

bind gif_lzw_decoder gld_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
